[hdl/dct_pkg.sv]
// Shared types and constants for the detection cluster tracker.
// Holds the entry layout, the command and status bundles between controller
// and datapath. No dependencies.
`default_nettype none

package dct_pkg;

    localparam int NUM_FIELDS = 6;   // x, y, z, red, green, blue
    localparam int FIELD_W    = 16;
    localparam int HITS_W     = 16;
    localparam int ENTRY_W    = 3 * 16 + 3 * 8 + HITS_W;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;
    localparam int RES_W      = 78;  // marker id plus position and color
    localparam int DIV_STEPS  = 34;  // numerator magnitude bits
    localparam int SQ_LAST    = 3;

    typedef struct packed {
        logic load_det;
        logic cap_ent;
        logic sq_step;
        logic cmp_any;
        logic idx_clr;
        logic idx_inc;
        logic mul;
        logic div_init;
        logic div_step;
        logic div_end;
        logic wr_entry;
        logic set_drop;
        logic app_entry;
        logic pend_load;
        logic out_load_pend;
        logic out_load_fin;
    } dct_cmd_t;

    typedef struct packed {
        logic idx_end;
        logic match;
        logic any_match;
        logic full;
        logic confirmed;
        logic out_free;
        logic pend_valid;
        logic sq_last;
        logic div_last;
        logic field_last;
    } dct_sts_t;

endpackage

`default_nettype wire

[hdl/dct_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module dct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  wire logic [WIDTH-1:0]               wdata,
    output logic      [WIDTH-1:0]               rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hdl/dct_ctrl.sv]
// Controller state machine for the detection cluster tracker.
// Depends on dct_pkg for the command and status bundles.
`default_nettype none

module dct_ctrl
    import dct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dct_sts_t sts,
    output dct_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_RDW  = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DVI  = 4'd6;
    localparam logic [3:0] S_DVS  = 4'd7;
    localparam logic [3:0] S_DVE  = 4'd8;
    localparam logic [3:0] S_WR   = 4'd9;
    localparam logic [3:0] S_CONF = 4'd10;
    localparam logic [3:0] S_PUSH = 4'd11;
    localparam logic [3:0] S_APP  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_det = 1'b1;
                    pass_next    = 1'b0;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                if (!sts.idx_end)
                begin
                    state_next = S_RDW;
                end
                else if (!pass_reg)
                begin
                    // first pass done: drop decision is now known
                    cmd.set_drop = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    pass_next    = 1'b1;
                end
                else if (!sts.any_match && !sts.full)
                begin
                    state_next = S_APP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RDW:
            begin
                cmd.cap_ent = 1'b1;
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (sts.sq_last)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!pass_reg)
                begin
                    cmd.cmp_any = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
                else if (sts.match)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_CONF;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DVI;
            end
            S_DVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DVS;
            end
            S_DVS:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DVE;
                end
            end
            S_DVE:
            begin
                cmd.div_end = 1'b1;
                state_next  = sts.field_last ? S_WR : S_MUL;
            end
            S_WR:
            begin
                cmd.wr_entry = 1'b1;
                state_next   = S_CONF;
            end
            S_CONF:
            begin
                if (sts.confirmed && sts.pend_valid)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.pend_load = sts.confirmed;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_pend = 1'b1;
                    cmd.pend_load     = 1'b1;
                    cmd.idx_inc       = 1'b1;
                    state_next        = S_RD;
                end
            end
            S_APP:
            begin
                cmd.app_entry = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_fin = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/dct_datapath.sv]
// Datapath for the detection cluster tracker: entry table, distance unit,
// running-mean multiply and bit-serial divider, result and output registers.
// Depends on dct_pkg and dct_ram.
`default_nettype none

module dct_datapath
    import dct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dct_cmd_t              cmd,
    output dct_sts_t                   sts,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [11:0]           match_radius,
    input  wire logic [15:0]           confirm_count,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                 m_tuser,
    output logic                       m_tlast
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic signed [15:0] det_reg [0:NUM_FIELDS-1];
    logic signed [15:0] ent_reg [0:NUM_FIELDS-1];
    logic [HITS_W-1:0]  hits_reg;
    logic [CNT_W-1:0]   idx_reg, used_reg;
    logic               any_reg, drop_reg, match_reg;
    logic [1:0]         sq_cnt_reg;
    logic [31:0]        sq_reg;
    logic [33:0]        acc_reg;
    logic [23:0]        r2_reg;
    logic [2:0]         fsel_reg;
    logic signed [32:0] prod_reg;
    logic [16:0]        divisor_reg;
    logic [16:0]        rem_reg;
    logic [33:0]        quo_reg;
    logic               neg_reg;
    logic [5:0]         div_cnt_reg;
    logic [6:0]         mark_cnt_reg;
    logic               pend_valid_reg;
    logic [RES_W-1:0]   pend_reg;
    logic               out_valid_reg;
    logic [RES_W-1:0]   out_data_reg;
    logic [1:0]         out_user_reg;
    logic               out_last_reg;

    // ---------------- entry table ----------------
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [HITS_W-1:0]  hits_sat;

    assign hits_sat = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
    assign ram_we   = cmd.wr_entry | cmd.app_entry;
    assign ram_addr = cmd.app_entry ? used_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_comb
    begin
        if (cmd.app_entry)
        begin
            ram_wdata = {HITS_W'(1), det_reg[5][7:0], det_reg[4][7:0], det_reg[3][7:0],
                         det_reg[2], det_reg[1], det_reg[0]};
        end
        else
        begin
            ram_wdata = {hits_sat, ent_reg[5][7:0], ent_reg[4][7:0], ent_reg[3][7:0],
                         ent_reg[2], ent_reg[1], ent_reg[0]};
        end
    end

    dct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---------------- arithmetic ----------------
    logic [2:0]         sq_sel;
    logic signed [16:0] diff;
    logic signed [33:0] sq_full;
    logic signed [16:0] n_s;
    logic signed [32:0] prod_full;
    logic signed [33:0] num;
    logic [17:0]        shifted;
    logic [18:0]        trial;
    logic [33:0]        quo_signed;

    assign sq_sel    = {1'b0, sq_cnt_reg};
    assign diff      = 17'(ent_reg[sq_sel]) - 17'(det_reg[sq_sel]);
    assign sq_full   = 34'(diff) * 34'(diff);
    assign n_s       = {1'b0, hits_reg};
    assign prod_full = 33'(ent_reg[fsel_reg]) * 33'(n_s);
    assign num       = 34'(prod_reg) + 34'(det_reg[fsel_reg]);
    assign shifted   = {rem_reg, quo_reg[33]};
    assign trial     = {1'b0, shifted} - {2'b00, divisor_reg};
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk)
    begin
        r2_reg <= match_radius * match_radius;
        if (cmd.load_det)
        begin
            det_reg[0] <= s_tdata[15:0];
            det_reg[1] <= s_tdata[31:16];
            det_reg[2] <= s_tdata[47:32];
            det_reg[3] <= {8'h00, s_tdata[55:48]};
            det_reg[4] <= {8'h00, s_tdata[63:56]};
            det_reg[5] <= {8'h00, s_tdata[71:64]};
        end
        if (cmd.cap_ent)
        begin
            ent_reg[0] <= ram_rdata[15:0];
            ent_reg[1] <= ram_rdata[31:16];
            ent_reg[2] <= ram_rdata[47:32];
            ent_reg[3] <= {8'h00, ram_rdata[55:48]};
            ent_reg[4] <= {8'h00, ram_rdata[63:56]};
            ent_reg[5] <= {8'h00, ram_rdata[71:64]};
            hits_reg   <= ram_rdata[87:72];
            acc_reg    <= '0;
        end
        else if (cmd.sq_step && sq_cnt_reg != 2'd0)
        begin
            acc_reg <= acc_reg + 34'(sq_reg);
        end
        if (cmd.sq_step)
        begin
            sq_reg <= sq_full[31:0];
        end
        if (cmd.mul)
        begin
            prod_reg    <= prod_full;
            divisor_reg <= 17'(hits_reg) + 17'd1;
        end
        if (cmd.div_init)
        begin
            neg_reg <= num[33];
            quo_reg <= num[33] ? 34'(-num) : 34'(num);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[18])
            begin
                rem_reg <= trial[16:0];
                quo_reg <= {quo_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[16:0];
                quo_reg <= {quo_reg[32:0], 1'b0};
            end
        end
        if (cmd.div_end)
        begin
            ent_reg[fsel_reg] <= quo_signed[15:0];
        end
        if (cmd.wr_entry)
        begin
            hits_reg <= hits_sat;
        end
        if (cmd.pend_load)
        begin
            pend_reg <= {ent_reg[5][7:0], ent_reg[4][7:0], ent_reg[3][7:0],
                         ent_reg[2], ent_reg[1], ent_reg[0], mark_cnt_reg[5:0]};
        end
        if (cmd.out_load_pend)
        begin
            out_data_reg <= pend_reg;
            out_user_reg <= {drop_reg, 1'b0};
            out_last_reg <= 1'b0;
        end
        else if (cmd.out_load_fin)
        begin
            out_data_reg <= pend_valid_reg ? pend_reg : '0;
            out_user_reg <= {drop_reg, ~pend_valid_reg};
            out_last_reg <= 1'b1;
        end
    end

    // ---------------- control counters and flags ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            idx_reg        <= '0;
            any_reg        <= 1'b0;
            drop_reg       <= 1'b0;
            match_reg      <= 1'b0;
            sq_cnt_reg     <= '0;
            fsel_reg       <= '0;
            div_cnt_reg    <= '0;
            mark_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_det)
            begin
                idx_reg        <= '0;
                any_reg        <= 1'b0;
                mark_cnt_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.cap_ent)
            begin
                sq_cnt_reg <= '0;
                fsel_reg   <= '0;
            end
            else if (cmd.sq_step)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            // last accumulate lands with the compare cycle
            if (cmd.sq_step && sq_cnt_reg == 2'(SQ_LAST))
            begin
                match_reg <= (acc_reg + 34'(sq_reg)) < 34'(r2_reg);
            end
            if (cmd.cmp_any && match_reg)
            begin
                any_reg <= 1'b1;
            end
            if (cmd.set_drop)
            begin
                drop_reg <= ~any_reg & (used_reg == DEPTH_C);
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.div_end)
            begin
                fsel_reg <= fsel_reg + 1'b1;
            end
            if (cmd.app_entry)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
                mark_cnt_reg   <= mark_cnt_reg + 1'b1;
            end
            else if (cmd.out_load_fin)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.out_load_pend || cmd.out_load_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.idx_end    = (idx_reg == used_reg);
    assign sts.match      = match_reg;
    assign sts.any_match  = any_reg;
    assign sts.full       = (used_reg == DEPTH_C);
    assign sts.confirmed  = (hits_reg >= confirm_count);
    assign sts.out_free   = ~out_valid_reg | m_tready;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.sq_last    = (sq_cnt_reg == 2'(SQ_LAST));
    assign sts.div_last   = (div_cnt_reg == 6'(DIV_STEPS - 1));
    assign sts.field_last = (fsel_reg == 3'(NUM_FIELDS - 1));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[hdl/detection_cluster_tracker_core.sv]
// Detection cluster tracker: leader clustering with a truncated running mean.
// Each detection walks the table twice: the first pass settles the drop flag, the second
// updates each matching entry one field at a time through the divider and pushes confirmed
// results ahead of the last; a detection that matched nothing is appended if there is room.
// Throughput: one detection at a time; s_tready is high only while idle.
// Reset (rst_n, async low) empties the table, restores match_radius 500, confirm_count 3.
`default_nettype none

module detection_cluster_tracker_core
    import dct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slave side: pos_x[15:0], pos_y[31:16], pos_z[47:32],
    // red_in[55:48], green_in[63:56], blue_in[71:64]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // master side: marker_id[5:0], out_x[21:6], out_y[37:22], out_z[53:38],
    // out_red[61:54], out_green[69:62], out_blue[77:70], zero fill [79:78]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // no_marker[0], dropped[1]
    output logic [1:0]                 m_tuser,
    // last_marker
    output logic                       m_tlast,
    // configuration: match_radius at 0x0, confirm_count at 0x4
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [11:0] match_radius_reg;
    logic [15:0] confirm_count_reg;
    logic        cfg_wr;

    dct_cmd_t cmd;
    dct_sts_t sts;

    // Register write completes on the access cycle; pready is tied high.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_radius_reg  <= 12'd500;
            confirm_count_reg <= 16'd3;
        end
        else if (cfg_wr)
        begin
            // word select on bit 2; lower address bits ignored
            if (paddr[2])
            begin
                confirm_count_reg <= pwdata[15:0];
            end
            else
            begin
                match_radius_reg <= pwdata[11:0];
            end
        end
    end

    assign prdata = paddr[2] ? {16'h0000, confirm_count_reg} : {20'h00000, match_radius_reg};

    // Controller sequences the walk; datapath holds the table and arithmetic.
    dct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_tdata       (s_tdata),
        .match_radius  (match_radius_reg),
        .confirm_count (confirm_count_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire
